// ===== hw/rtl/vad_pkg.sv =====
// Shared constants, types and the arctangent table for the vector angle unit.
package vad_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 7;

    localparam int FIELD_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int ACC_FRAC  = 24;
    localparam int TABLE_LEN = 24;
    localparam int NUM_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int TAB_IDX_W = $clog2(TABLE_LEN);

    // Magnitudes are pre-scaled so that the top of the 60-bit frame is used.
    localparam int PRE_SHIFT = 60 - COORD_WIDTH;
    // The rotated magnitude grows by up to sqrt(2) * 1.65, two bits above the frame.
    localparam int CR_W      = 62;
    localparam int Z_W       = 32;
    localparam int ACC_W     = 33;
    localparam int DROP      = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int ROUND_W   = ACC_W - DROP;

    // Pipeline depth from an accepted start to the done strobe.
    localparam int LATENCY   = NUM_STAGES + 3;

    typedef logic signed [CR_W-1:0] t_coord;
    typedef logic signed [Z_W-1:0]  t_zacc;
    typedef logic [ACC_W-1:0]       t_acc;
    typedef logic [ANGLE_W-1:0]     t_angle;

    localparam t_angle ANG_0   = ANGLE_W'(0);
    localparam t_angle ANG_90  = ANGLE_W'(64'd90  << ANGLE_FRAC_BITS);
    localparam t_angle ANG_180 = ANGLE_W'(64'd180 << ANGLE_FRAC_BITS);
    localparam t_angle ANG_270 = ANGLE_W'(64'd270 << ANGLE_FRAC_BITS);

    localparam t_acc QUARTER_TURN = ACC_W'(64'd90  << ACC_FRAC);
    localparam t_acc HALF_TURN    = ACC_W'(64'd180 << ACC_FRAC);
    localparam t_acc FULL_TURN    = ACC_W'(64'd360 << ACC_FRAC);
    localparam t_acc ROUND_HALF   = ACC_W'(64'd1 << (DROP - 1));

    localparam logic [ROUND_W-1:0] FULL_UNITS = ROUND_W'(64'd360 << ANGLE_FRAC_BITS);

    // atan(2^-i) in units of 2^-24 degree, rounded to nearest.
    localparam t_zacc ATAN_TAB [TABLE_LEN] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    typedef struct packed {
        logic   special;
        t_angle spec_angle;
        logic   x_neg;
        logic   y_neg;
        t_coord cx;
        t_coord cy;
        t_zacc  z;
    } t_cordic;

endpackage

// ===== hw/rtl/vad_prep.sv =====
// Input stage: special-case detection, magnitudes and pre-scaling.
module vad_prep (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [vad_pkg::FIELD_W-1:0] i_x_coord,
    input  logic [vad_pkg::FIELD_W-1:0] i_y_coord,
    output logic                      o_valid,
    output vad_pkg::t_cordic          o_data
);
    import vad_pkg::*;

    logic signed [COORD_WIDTH-1:0] x_c;
    logic signed [COORD_WIDTH-1:0] y_c;
    logic [COORD_WIDTH:0]          x_ext;
    logic [COORD_WIDTH:0]          y_ext;
    logic [COORD_WIDTH:0]          x_abs;
    logic [COORD_WIDTH:0]          y_abs;
    logic                          x_zero;
    logic                          y_zero;
    logic                          r_valid;
    t_cordic                       r_data;
    t_cordic                       n_data;

    assign x_c    = i_x_coord[COORD_WIDTH-1:0];
    assign y_c    = i_y_coord[COORD_WIDTH-1:0];
    assign x_ext  = {x_c[COORD_WIDTH-1], x_c};
    assign y_ext  = {y_c[COORD_WIDTH-1], y_c};
    assign x_abs  = x_c[COORD_WIDTH-1] ? (~x_ext + 1'b1) : x_ext;
    assign y_abs  = y_c[COORD_WIDTH-1] ? (~y_ext + 1'b1) : y_ext;
    assign x_zero = (x_c == '0);
    assign y_zero = (y_c == '0);

    always_comb begin
        n_data.special = x_zero || y_zero;
        if (x_zero) begin
            n_data.spec_angle = y_c[COORD_WIDTH-1] ? ANG_270 : ANG_90;
        end else begin
            n_data.spec_angle = x_c[COORD_WIDTH-1] ? ANG_180 : ANG_0;
        end
        n_data.x_neg = x_c[COORD_WIDTH-1];
        n_data.y_neg = y_c[COORD_WIDTH-1];
        n_data.cx    = {{(CR_W-COORD_WIDTH-1){1'b0}}, x_abs} << PRE_SHIFT;
        n_data.cy    = {{(CR_W-COORD_WIDTH-1){1'b0}}, y_abs} << PRE_SHIFT;
        n_data.z     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/vad_cell.sv =====
// One CORDIC vectoring micro-rotation with its pipeline register.
module vad_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [vad_pkg::TAB_IDX_W-1:0] i_stage,
    input  logic                        i_valid,
    input  vad_pkg::t_cordic            i_data,
    output logic                        o_valid,
    output vad_pkg::t_cordic            o_data
);
    import vad_pkg::*;

    t_coord  cx;
    t_coord  cy;
    t_zacc   z;
    t_coord  dx;
    t_coord  dy;
    t_zacc   step;
    logic    r_valid;
    t_cordic r_data;
    t_cordic n_data;

    assign cx   = i_data.cx;
    assign cy   = i_data.cy;
    assign z    = i_data.z;
    // Arithmetic shift of a signed value rounds toward minus infinity.
    assign dx   = cy >>> i_stage;
    assign dy   = cx >>> i_stage;
    assign step = ATAN_TAB[i_stage];

    always_comb begin
        n_data = i_data;
        if (!cy[CR_W-1]) begin
            n_data.cx = cx + dx;
            n_data.cy = cy - dy;
            n_data.z  = z + step;
        end else begin
            n_data.cx = cx - dx;
            n_data.cy = cy + dy;
            n_data.z  = z - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/vad_post.sv =====
// Output stages: clamp, quadrant correction, rounding, wrap to a full turn and special-case select.
module vad_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  vad_pkg::t_cordic     i_data,
    output logic                 o_valid,
    output vad_pkg::t_angle      o_angle
);
    import vad_pkg::*;

    logic [Z_W-1:0]     z_u;
    t_acc               z_ext;
    t_acc               z_clamp;
    t_acc               n_acc;
    logic               r_valid_a;
    t_acc               r_acc;
    logic               r_special;
    t_angle             r_spec_angle;
    t_acc               rnd_sum;
    logic [ROUND_W-1:0] rnd;
    logic [ROUND_W-1:0] wrapped;
    t_angle             n_angle;
    logic               r_valid_b;
    t_angle             r_angle;

    assign z_u   = i_data.z;
    assign z_ext = ACC_W'(z_u);

    always_comb begin
        if (i_data.z[Z_W-1]) begin
            z_clamp = '0;
        end else if (z_ext > QUARTER_TURN) begin
            z_clamp = QUARTER_TURN;
        end else begin
            z_clamp = z_ext;
        end
    end

    always_comb begin
        unique case ({i_data.y_neg, i_data.x_neg})
            2'b00:   n_acc = z_clamp;
            2'b01:   n_acc = HALF_TURN - z_clamp;
            2'b11:   n_acc = HALF_TURN + z_clamp;
            2'b10:   n_acc = FULL_TURN - z_clamp;
            default: n_acc = z_clamp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_special    <= i_data.special;
        r_spec_angle <= i_data.spec_angle;
        r_angle      <= n_angle;
    end

    // Round half up, then fold a result of exactly one full turn back to zero.
    assign rnd_sum = r_acc + ROUND_HALF;
    assign rnd     = rnd_sum[ACC_W-1:DROP];
    assign wrapped = (rnd >= FULL_UNITS) ? (rnd - FULL_UNITS) : rnd;
    assign n_angle = r_special ? r_spec_angle : ANGLE_W'(wrapped);

    assign o_valid = r_valid_b;
    assign o_angle = r_angle;

endmodule

// ===== hw/rtl/vector_angle_degrees_unit.sv =====
// Top level of the vector angle unit: input stage, CORDIC cell chain, output stages.
//
// Gives the counterclockwise angle of the vector (x, y) in 1/128 degree, 0 to below 360.
// The unit is a fully pipelined row of CORDIC cells: it takes one vector on every clock
// cycle, so busy stays low, and each result appears on o_angle with a one-cycle o_done
// strobe once the vector has passed one input stage, 16 rotation cells and two output stages,
// each registered, in that order. Results leave in the order the vectors came in and
// must be captured in the strobe cycle, since the unit holds nothing for a late receiver.
module vector_angle_degrees_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [vad_pkg::FIELD_W-1:0] i_x_coord,
    input  logic [vad_pkg::FIELD_W-1:0] i_y_coord,
    output logic                        o_done,
    output logic [vad_pkg::ANGLE_W-1:0] o_angle
);
    import vad_pkg::*;

    logic    chain_valid [NUM_STAGES+1];
    t_cordic chain_data  [NUM_STAGES+1];
    logic    accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    vad_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_valid   (chain_valid[0]),
        .o_data    (chain_data[0])
    );

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
        vad_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (TAB_IDX_W'(g)),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    vad_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[NUM_STAGES]),
        .i_data  (chain_data[NUM_STAGES]),
        .o_valid (o_done),
        .o_angle (o_angle)
    );

endmodule

// ===== hw/rtl/vad_checker.sv =====
// Port-level checks for the vector angle unit and their bind to the top level.
module vad_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [vad_pkg::FIELD_W-1:0] i_x_coord,
    input logic [vad_pkg::FIELD_W-1:0] i_y_coord,
    input logic                        o_done,
    input logic [vad_pkg::ANGLE_W-1:0] o_angle
);
    import vad_pkg::*;

    // Every accepted transaction yields its result after the fixed pipeline depth.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("accepted transaction produced no result at the expected cycle");

    // No result appears without a transaction accepted the pipeline depth earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && i_rst_n, LATENCY))
        else $error("result strobe without a matching accepted transaction");

    // Angles stay below a full turn.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_angle < ANGLE_W'(FULL_UNITS)))
        else $error("angle reached or passed a full turn");

    // A vector on the nonnegative y axis (origin included) points at 90 degrees.
    a_pos_y_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_x_coord[COORD_WIDTH-1:0] == '0)
            && !i_y_coord[COORD_WIDTH-1]) |-> ##LATENCY (o_angle == ANG_90))
        else $error("vector on the positive y axis did not give 90 degrees");

endmodule

bind vector_angle_degrees_unit vad_checker u_vad_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the vector angle unit: directed vectors, then random ones.
`timescale 1ns / 100ps

module testbench;

    import vad_pkg::*;

    typedef logic signed [FIELD_W-1:0] t_vec_coord;

    typedef struct {
        t_vec_coord x;
        t_vec_coord y;
        logic       typed;
        t_angle     angle;
    } t_vec_row;

    // Arctangent of 2^-i in units of 2^-24 degree.
    localparam int ATAN_LEN = 24;
    localparam longint ATAN_DEG_Q24 [ATAN_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };
    localparam int Z_FRAC = 24;

    // Expected angles are typed in only where a vector lies on an axis.
    localparam int NUM_DIRECTED = 23;
    t_vec_row directed_rows [NUM_DIRECTED] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'd11520},
        '{16'sd0,      16'sd1,      1'b1, 16'd11520},
        '{16'sd0,      16'sd32767,  1'b1, 16'd11520},
        '{16'sd0,      -16'sd1,     1'b1, 16'd34560},
        '{16'sd0,      16'sh8000,   1'b1, 16'd34560},
        '{16'sd1,      16'sd0,      1'b1, 16'd0},
        '{16'sd32767,  16'sd0,      1'b1, 16'd0},
        '{-16'sd1,     16'sd0,      1'b1, 16'd23040},
        '{16'sh8000,   16'sd0,      1'b1, 16'd23040},
        '{16'sd32767,  16'sd32767,  1'b0, 16'd0},
        '{16'sh8000,   16'sd32767,  1'b0, 16'd0},
        '{16'sh8000,   16'sh8000,   1'b0, 16'd0},
        '{16'sd32767,  16'sh8000,   1'b0, 16'd0},
        '{16'sd1,      16'sd1,      1'b0, 16'd0},
        '{-16'sd1,     16'sd1,      1'b0, 16'd0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'd0},
        '{16'sd1,      -16'sd1,     1'b0, 16'd0},
        '{16'sd32767,  -16'sd1,     1'b0, 16'd0},
        '{16'sd32767,  16'sd1,      1'b0, 16'd0},
        '{16'sh8000,   16'sd1,      1'b0, 16'd0},
        '{16'sh8000,   -16'sd1,     1'b0, 16'd0},
        '{16'sd1,      16'sd32767,  1'b0, 16'd0},
        '{-16'sd1,     16'sh8000,   1'b0, 16'd0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [FIELD_W-1:0] i_x_coord;
    logic [FIELD_W-1:0] i_y_coord;
    logic               o_done;
    logic [ANGLE_W-1:0] o_angle;

    t_angle pending_angles [$];
    int     error_count;
    int     vectors_sent;
    int     angles_checked;
    int     axis_vectors;
    int     wrapped_angles;

    vector_angle_degrees_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_x_coord(i_x_coord),
        .i_y_coord(i_y_coord),
        .o_done   (o_done),
        .o_angle  (o_angle)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Axis cases first, else CORDIC vectoring on the magnitudes, then clamp, quadrant fold, rounding and wrap.
    function automatic t_angle heading_of(t_vec_coord x, t_vec_coord y);
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint z;
        longint a;
        longint r;
        longint full_units;
        int     drop;
        full_units = longint'(360) <<< ANGLE_FRAC_BITS;
        if (x == 0) begin
            return t_angle'((y < 0 ? 270 : 90) << ANGLE_FRAC_BITS);
        end
        if (y == 0) begin
            return t_angle'((x < 0 ? 180 : 0) << ANGLE_FRAC_BITS);
        end
        cx = (x < 0) ? -longint'(x) : longint'(x);
        cy = (y < 0) ? -longint'(y) : longint'(y);
        cx = cx <<< (60 - COORD_WIDTH);
        cy = cy <<< (60 - COORD_WIDTH);
        z = 0;
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + ATAN_DEG_Q24[i];
            end else begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - ATAN_DEG_Q24[i];
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(90) <<< Z_FRAC)) z = longint'(90) <<< Z_FRAC;
        if (y > 0) begin
            a = (x > 0) ? z : (longint'(180) <<< Z_FRAC) - z;
        end else begin
            a = (x > 0) ? (longint'(360) <<< Z_FRAC) - z : (longint'(180) <<< Z_FRAC) + z;
        end
        drop = Z_FRAC - ANGLE_FRAC_BITS;
        r = (a + (longint'(1) <<< (drop - 1))) >>> drop;
        if (r >= full_units) r = r - full_units;
        return t_angle'(r);
    endfunction

    function automatic t_vec_coord pick_coord();
        t_vec_coord c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c = t_vec_coord'($urandom());
            5, 6:          c = t_vec_coord'($urandom_range(0, 16)) - 16'sd8;
            7:             c = '0;
            8: begin
                case ($urandom_range(0, 4))
                    0:       c = 16'sd32767;
                    1:       c = 16'sh8000;
                    2:       c = -16'sd32767;
                    3:       c = 16'sd1;
                    default: c = -16'sd1;
                endcase
            end
            default:       c = t_vec_coord'($urandom()) >>> $urandom_range(0, 15);
        endcase
        return c;
    endfunction

    task automatic send_vector(t_vec_coord x, t_vec_coord y, logic typed, t_angle typed_angle);
        @(negedge i_clk);
        start     <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_angles.push_back(typed ? typed_angle : heading_of(x, y));
        vectors_sent++;
        if (x == 0 || y == 0) axis_vectors++;
        else if (heading_of(x, y) == 0) wrapped_angles++;
    endtask

    task automatic hold_off(int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_angles.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(int count, int idle_pct);
        for (int n = 0; n < count; n++) begin
            hold_off(idle_pct);
            send_vector(pick_coord(), pick_coord(), 1'b0, '0);
        end
        drain_pipeline();
    endtask

    always @(posedge i_clk) begin
        t_angle want;
        if (i_rst_n && o_done) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected angle transaction, expected none, actual %0d",
                         $time, o_angle);
                error_count++;
            end else begin
                want = pending_angles.pop_front();
                angles_checked++;
                if (o_angle !== want) begin
                    $display("%0t: angle mismatch, expected %0d, actual %0d",
                             $time, want, o_angle);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        error_count    = 0;
        vectors_sent   = 0;
        angles_checked = 0;
        axis_vectors   = 0;
        wrapped_angles = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_vector(directed_rows[k].x, directed_rows[k].y,
                        directed_rows[k].typed, directed_rows[k].angle);
        end
        // Let the directed transactions leave the pipeline before random traffic.
        drain_pipeline();

        random_phase(650, 14);
        random_phase(650, 80);
        random_phase(650, 0);

        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Sent %0d vectors (%0d on an axis, %0d rounding to a full turn).",
                 vectors_sent, axis_vectors, wrapped_angles);
        $display("Checked %0d angles with %0d mismatches.", angles_checked, error_count);
        if (error_count == 0 && pending_angles.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
